[rtl/jsv_pkg.sv]
`timescale 1ns / 1ps
package jsv_pkg;

   localparam int MAX_DEPTH = 64;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   localparam logic [1:0] OP_FEED = 2'd0;
   localparam logic [1:0] OP_PROBE = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [1:0] SK_NONE = 2'd0;
   localparam logic [1:0] SK_STRING = 2'd1;
   localparam logic [1:0] SK_NUMBER = 2'd2;
   localparam logic [1:0] SK_LITERAL = 2'd3;

   // Number lexer states.
   localparam logic [2:0] NUM_SIGN = 3'd0;
   localparam logic [2:0] NUM_ZERO = 3'd1;
   localparam logic [2:0] NUM_INT = 3'd2;
   localparam logic [2:0] NUM_DOT = 3'd3;
   localparam logic [2:0] NUM_FRAC = 3'd4;
   localparam logic [2:0] NUM_EXP = 3'd5;
   localparam logic [2:0] NUM_EXP_SIGN = 3'd6;
   localparam logic [2:0] NUM_EXP_DIG = 3'd7;

   localparam logic [15:0] SURR_LO = 16'hd800;
   localparam logic [15:0] SURR_HI = 16'hdfff;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // Frame: bit0 kind (0 object, 1 array), bits 2..1 expectation, bit3 close allowed.
   typedef logic [3:0] frame_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      frame_type top;
      frame_type below;
      logic [1:0] kind;
      logic key;
      logic esc;
      logic [2:0] hex;
      logic [15:0] acc;
      logic [2:0] num;
      logic [1:0] lsel;
      logic [2:0] lpos;
      logic root;
      logic done;
   } vst_type;

   typedef struct packed {
      logic ok;
      logic ovf;
      logic push;
      vst_type s;
   } vres_type;

   function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (sel)
         2'd0: begin
            case (pos)
               3'd0: ch = "t";
               3'd1: ch = "r";
               3'd2: ch = "u";
               3'd3: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         2'd1: begin
            case (pos)
               3'd0: ch = "f";
               3'd1: ch = "a";
               3'd2: ch = "l";
               3'd3: ch = "s";
               3'd4: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         2'd2: begin
            case (pos)
               3'd0: ch = "n";
               3'd1: ch = "u";
               3'd2: ch = "l";
               3'd3: ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] sel);
      return (sel == 2'd1) ? 3'd5 : 3'd4;
   endfunction

endpackage

[rtl/json_syntax_stream_validator_unit.sv]
`timescale 1ns / 1ps
// Channel   | Direction | Beat contents
// req       | in        | opcode, data_byte
// rsp       | out       | accepted, doc_complete, nesting_level, depth_overflow
// csr (APB) | in/out    | register 0: root_must_be_object
//
// One beat is accepted per cycle while req_ready is high; its verdict is registered for rsp.
// The rate is set by the read-modify-write of the frame held on top of the stack, in st_ff;
// the frame below it is prefetched from the stack memory every cycle.
// Reset is synchronous and clears all control state; the stack memory is not cleared.
// A two-entry output stage (result register plus skid) absorbs one more beat while rsp
// stalls; req_ready drops once both entries are full and rises again when rsp drains.
module json_syntax_stream_validator_unit
   import jsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_doc_complete,
   output logic [6:0]  rsp_nesting_level,
   output logic        rsp_depth_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef struct packed {
      logic ok;
      logic done;
      logic [6:0] lvl;
      logic ovf;
   } rsp_type;

   // Stack memory holds every open frame except the top one, which lives in st_ff.
   frame_type mem [MAX_DEPTH];
   frame_type rd_ff;

   vst_type st_ff, st_in;
   logic rmo_ff;
   rsp_type out_ff, skid_ff, res;
   logic out_v_ff, skid_v_ff;

   logic acc, take, mem_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   vres_type fr;

   function automatic logic is_ws(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic vst_type clr(input vst_type s);
      vst_type t;
      t = s;
      t.kind = SK_NONE; t.key = 1'b0; t.esc = 1'b0; t.hex = 3'd0;
      t.acc = 16'd0; t.num = NUM_SIGN; t.lsel = 2'd0; t.lpos = 3'd0;
      return t;
   endfunction

   function automatic vres_type fail(input vst_type s);
      vres_type r;
      r.ok = 1'b0; r.ovf = 1'b0; r.push = 1'b0; r.s = s;
      return r;
   endfunction

   function automatic vres_type pass(input vst_type s);
      vres_type r;
      r.ok = 1'b1; r.ovf = 1'b0; r.push = 1'b0; r.s = s;
      return r;
   endfunction

   function automatic vres_type f_complete(input vst_type s);
      vst_type t;
      vres_type r;
      t = s;
      r = pass(t);
      if (t.cnt == '0) begin
         r.s.done = 1'b1;
      end else if (!t.top[0]) begin
         if (t.top[2:1] != 2'd2) r.ok = 1'b0;
         else r.s.top = {t.top[3], 2'd3, 1'b0};
      end else begin
         if (t.top[2:1] != 2'd0) r.ok = 1'b0;
         else r.s.top = {t.top[3], 2'd1, 1'b1};
      end
      return r;
   endfunction

   function automatic vres_type f_pop(input vst_type s);
      vst_type t;
      t = s;
      t.cnt = s.cnt - 1'b1;
      t.top = s.below;
      return f_complete(t);
   endfunction

   function automatic vres_type f_finish(input vst_type s);
      vst_type t;
      vres_type r;
      t = s;
      r = fail(s);
      if (s.kind != SK_NONE) begin
         if (s.key) begin
            if (s.cnt != '0 && !s.top[0] && s.top[2:1] == 2'd0) begin
               t = clr(s);
               t.top = {s.top[3], 2'd1, 1'b0};
               r = pass(t);
            end
         end else begin
            t = clr(s);
            if (t.cnt == '0) begin
               t.done = 1'b1;
               r = pass(t);
            end else begin
               r = f_complete(t);
            end
         end
      end
      return r;
   endfunction

   function automatic vres_type f_start(input vst_type s, input logic [7:0] c,
                                        input logic rmo);
      vst_type t;
      vres_type r;
      t = s;
      r = fail(s);
      if (!(s.cnt == '0 && !s.root && rmo && c != "{")) begin
         if (s.cnt == '0) t.root = 1'b1;
         if (c == "{" || c == "[") begin
            if (s.cnt >= CNT_W'(MAX_DEPTH)) begin
               r.ovf = 1'b1;
            end else begin
               t.below = s.top;
               t.top = {1'b1, 2'd0, c == "["};
               t.cnt = s.cnt + 1'b1;
               r = pass(t);
               r.push = s.cnt != '0;
            end
         end else begin
            t = clr(t);
            if (c == "\"") begin
               t.kind = SK_STRING;
               r = pass(t);
            end else if (c == "-" || is_dig(c)) begin
               t.kind = SK_NUMBER;
               t.num = (c == "-") ? NUM_SIGN : ((c == "0") ? NUM_ZERO : NUM_INT);
               r = pass(t);
            end else if (c == "t" || c == "f" || c == "n") begin
               t.kind = SK_LITERAL;
               t.lsel = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
               t.lpos = 3'd1;
               r = pass(t);
            end
         end
      end
      return r;
   endfunction

   // Byte handled by the container context (no scalar active).
   function automatic vres_type f_ctx(input vst_type s, input logic [7:0] c,
                                      input logic rmo);
      vst_type t;
      vres_type r;
      t = s;
      r = fail(s);
      if (s.done) begin
         r.ok = is_ws(c);
      end else if (s.cnt == '0) begin
         if (!s.root) begin
            if (is_ws(c)) r = pass(s);
            else r = f_start(s, c, rmo);
         end
      end else if (is_ws(c)) begin
         r = pass(s);
      end else if (!s.top[0]) begin
         case (s.top[2:1])
            2'd0: begin
               if (c == "\"") begin
                  t = clr(s);
                  t.kind = SK_STRING;
                  t.key = 1'b1;
                  r = pass(t);
               end else if (c == "}" && s.top[3]) begin
                  r = f_pop(s);
               end
            end
            2'd1: begin
               if (c == ":") begin
                  t.top = {s.top[3], 2'd2, 1'b0};
                  r = pass(t);
               end
            end
            2'd2: r = f_start(s, c, rmo);
            default: begin
               if (c == ",") begin
                  t.top = 4'b0000;
                  r = pass(t);
               end else if (c == "}") begin
                  r = f_pop(s);
               end
            end
         endcase
      end else begin
         if (s.top[2:1] == 2'd0) begin
            if (c == "]") begin
               if (s.top[3]) r = f_pop(s);
            end else begin
               r = f_start(s, c, rmo);
            end
         end else if (s.top[2:1] == 2'd1) begin
            if (c == ",") begin
               t.top = 4'b0001;
               r = pass(t);
            end else if (c == "]") begin
               r = f_pop(s);
            end
         end
      end
      return r;
   endfunction

   function automatic vres_type f_feed(input vst_type s, input logic [7:0] c,
                                       input logic rmo);
      vst_type t;
      vres_type r;
      logic hv;
      logic [3:0] hd;
      logic [15:0] an;
      t = s;
      r = fail(s);
      hv = 1'b1;
      hd = 4'd0;
      an = 16'd0;
      if (s.done) begin
         r.ok = is_ws(c);
      end else if (s.kind == SK_STRING) begin
         if (s.hex != 3'd0) begin
            if (is_dig(c)) hd = c[3:0];
            else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) hd = c[3:0] + 4'd9;
            else hv = 1'b0;
            an = {s.acc[11:0], hd};
            if (hv) begin
               t.acc = an;
               t.hex = s.hex - 3'd1;
               if (t.hex == 3'd0) begin
                  t.acc = 16'd0;
                  if (!(an >= SURR_LO && an <= SURR_HI)) r = pass(t);
               end else begin
                  r = pass(t);
               end
            end
         end else if (s.esc) begin
            t.esc = 1'b0;
            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                c == "n" || c == "r" || c == "t") begin
               r = pass(t);
            end else if (c == "u") begin
               t.hex = 3'd4;
               t.acc = 16'd0;
               r = pass(t);
            end
         end else if (c == "\"") begin
            r = f_finish(s);
         end else if (c == "\\") begin
            t.esc = 1'b1;
            r = pass(t);
         end else if (c >= CTRL_LIMIT) begin
            r = pass(s);
         end
      end else if (s.kind == SK_LITERAL) begin
         if (s.lsel != 2'd3 && s.lpos < lit_len(s.lsel) && c == lit_char(s.lsel, s.lpos)) begin
            t.lpos = s.lpos + 3'd1;
            if (t.lpos == lit_len(s.lsel)) r = f_finish(t);
            else r = pass(t);
         end
      end else if (s.kind == SK_NUMBER) begin
         case (s.num)
            NUM_SIGN: begin
               if (c == "0") begin
                  t.num = NUM_ZERO; r = pass(t);
               end else if (c >= "1" && c <= "9") begin
                  t.num = NUM_INT; r = pass(t);
               end
            end
            NUM_DOT: begin
               if (is_dig(c)) begin
                  t.num = NUM_FRAC; r = pass(t);
               end
            end
            NUM_EXP: begin
               if (c == "+" || c == "-") begin
                  t.num = NUM_EXP_SIGN; r = pass(t);
               end else if (is_dig(c)) begin
                  t.num = NUM_EXP_DIG; r = pass(t);
               end
            end
            NUM_EXP_SIGN: begin
               if (is_dig(c)) begin
                  t.num = NUM_EXP_DIG; r = pass(t);
               end
            end
            default: begin
               if (is_dig(c) && s.num != NUM_ZERO) begin
                  r = pass(s);
               end else if (c == "." && (s.num == NUM_ZERO || s.num == NUM_INT)) begin
                  t.num = NUM_DOT; r = pass(t);
               end else if ((c == "e" || c == "E") && s.num != NUM_EXP_DIG) begin
                  t.num = NUM_EXP; r = pass(t);
               end else if ((is_ws(c) || c == "," || c == "}" || c == "]")) begin
                  // A delimiter ends the number and is then handled by the context.
                  r = f_finish(s);
                  if (r.ok) r = f_ctx(r.s, c, rmo);
               end
            end
         endcase
      end else begin
         r = f_ctx(s, c, rmo);
      end
      return r;
   endfunction

   assign req_ready = !skid_v_ff;
   assign acc = req_valid && req_ready;
   assign take = out_v_ff && rsp_ready;

   always_comb begin
      vst_type cur;
      cur = st_ff;
      cur.below = rd_ff;
      fr = f_feed(cur, req_data_byte, rmo_ff);
      st_in = st_ff;
      mem_we = 1'b0;
      res.ok = fr.ok;
      res.ovf = fr.ovf;
      if (acc) begin
         if (req_opcode == OP_RESTART) begin
            st_in = '0;
            res.ok = 1'b1;
            res.ovf = 1'b0;
         end else if (req_opcode == OP_FEED && fr.ok) begin
            st_in = fr.s;
            mem_we = fr.push;
         end
      end
      res.done = st_in.done || (st_in.root && st_in.cnt == '0 && st_in.kind == SK_NUMBER &&
                 (st_in.num == NUM_ZERO || st_in.num == NUM_INT ||
                  st_in.num == NUM_FRAC || st_in.num == NUM_EXP_DIG));
      res.lvl = 7'(st_in.cnt);
   end

   // The old top goes to slot cnt-1; the frame below the next top sits at slot cnt_in-2.
   assign wr_addr = ADDR_W'(st_ff.cnt - 1'b1);
   assign rd_addr = ADDR_W'(st_in.cnt - 2'd2);

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= st_ff.top;
      if (mem_we && wr_addr == rd_addr) rd_ff <= st_ff.top;
      else rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         rmo_ff <= 1'b0;
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (psel && penable && pwrite && paddr == 3'd0) rmo_ff <= pwdata[0];
         if (!out_v_ff || take) begin
            out_v_ff <= skid_v_ff || acc;
            skid_v_ff <= 1'b0;
         end else if (acc) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (acc) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_accepted = out_ff.ok;
   assign rsp_doc_complete = out_ff.done;
   assign rsp_nesting_level = out_ff.lvl;
   assign rsp_depth_overflow = out_ff.ovf;

   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? {31'd0, rmo_ff} : 32'd0;

endmodule
